/* src/servo_reply_frame_parser_unit_defines.svh */
// ----------------------------------------------------------------------------
// Servo reply frame parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH
`define SERVO_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define SRFP_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define SRFP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* src/srfp_pkg.sv */
// ----------------------------------------------------------------------------
// Servo reply frame parser package
// Character codes, frame layout, status codes and register defaults.
// ----------------------------------------------------------------------------
package srfp_pkg;

    localparam int FRAME_BYTES_DEFAULT = 24;

    localparam logic [7:0] CH_START = 8'h23;  // '#'
    localparam logic [7:0] CH_END   = 8'h21;  // '!'
    localparam logic [7:0] CH_POS   = 8'h50;  // 'P'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // byte offsets and minimum length of a frame
    localparam int ID_LAST_OFS    = 3;
    localparam int POS_MARK_OFS   = 4;
    localparam int MIN_FRAME_SIZE = 6;

    typedef enum logic [1:0] {
        CFG_MAX_SERVO_ID = 2'd0,
        CFG_MIN_POSITION = 2'd1,
        CFG_MAX_POSITION = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2
    } frame_status_t;

    localparam logic [7:0]  RST_MAX_SERVO_ID = 8'd254;
    localparam logic [15:0] RST_MIN_POSITION = 16'd500;
    localparam logic [15:0] RST_MAX_POSITION = 16'd2500;

endpackage

/* src/servo_reply_frame_parser_unit.sv */
// Takes one received byte per clock and emits one result word for each servo
// reply frame closed by '!' within FRAME_BYTES - 1 bytes, in the cycle after
// that byte is taken. Input bytes are accepted every cycle while the result
// register is empty or being drained; the only stall comes from a held result.
// ----------------------------------------------------------------------------
// Servo reply frame parser
// Parses "#nnnP<digits>!" frames and checks id and position limits.
// ----------------------------------------------------------------------------
`include "servo_reply_frame_parser_unit_defines.svh"

module servo_reply_frame_parser_unit
    import srfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] servo_id, [23:8] position
    output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

    logic [7:0]       max_servo_id_reg;
    logic [15:0]      min_position_reg;
    logic [15:0]      max_position_reg;

    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic             frame_done_reg, frame_done_next;
    logic [9:0]       id_accum_reg, id_accum_next;
    logic [15:0]      pos_accum_reg, pos_accum_next;
    logic             format_bad_reg, format_bad_next;
    logic             digits_ended_reg, digits_ended_next;

    logic             out_valid_reg;
    frame_status_t    status_reg, status_next;
    logic [7:0]       servo_id_reg, servo_id_next;
    logic [15:0]      position_reg, position_next;

    logic             in_accept;
    logic             emit;
    logic [7:0]       rx_byte;
    logic             is_digit;
    logic [3:0]       digit;

    assign rx_byte       = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_digit      = rx_byte inside {[CH_ZERO:CH_NINE]};
    assign digit         = 4'(rx_byte - CH_ZERO);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_servo_id_reg <= RST_MAX_SERVO_ID;
            min_position_reg <= RST_MIN_POSITION;
            max_position_reg <= RST_MAX_POSITION;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAX_SERVO_ID: max_servo_id_reg <= cfg_data[7:0];
                CFG_MIN_POSITION: min_position_reg <= cfg_data;
                CFG_MAX_POSITION: max_position_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // parse step
    always_comb
    begin
        logic [CNT_W-1:0] k;
        logic             done_v;

        k                 = frame_count_reg;
        done_v            = frame_done_reg;
        frame_count_next  = frame_count_reg;
        frame_done_next   = frame_done_reg;
        id_accum_next     = id_accum_reg;
        pos_accum_next    = pos_accum_reg;
        format_bad_next   = format_bad_reg;
        digits_ended_next = digits_ended_reg;
        emit              = 1'b0;
        status_next       = ST_VALID;
        servo_id_next     = 8'd0;
        position_next     = 16'd0;

        if (in_accept)
        begin
            if (rx_byte == CH_START)
            begin
                k      = '0;
                done_v = 1'b0;
            end
            frame_count_next = k;
            frame_done_next  = done_v;

            if (!done_v && !(k == '0 && rx_byte != CH_START))
            begin
                if (k >= CNT_LAST)
                begin
                    frame_count_next = '0;
                    frame_done_next  = 1'b0;
                end
                else
                begin
                    if (k == '0)
                    begin
                        id_accum_next     = '0;
                        pos_accum_next    = '0;
                        format_bad_next   = 1'b0;
                        digits_ended_next = 1'b0;
                    end
                    else if (k <= CNT_W'(ID_LAST_OFS))
                    begin
                        if (is_digit)
                            id_accum_next = 10'(id_accum_reg * 10'd10 + 10'(digit));
                        else
                            format_bad_next = 1'b1;
                    end
                    else if (k == CNT_W'(POS_MARK_OFS))
                    begin
                        if (rx_byte != CH_POS)
                            format_bad_next = 1'b1;
                    end
                    else if (rx_byte != CH_END)
                    begin
                        if (is_digit && !digits_ended_reg)
                            pos_accum_next = 16'(pos_accum_reg * 16'd10 + 16'(digit));
                        else
                        begin
                            digits_ended_next = 1'b1;
                            format_bad_next   = 1'b1;
                        end
                    end

                    frame_count_next = k + 1'b1;

                    if (rx_byte == CH_END)
                    begin
                        frame_done_next = 1'b1;
                        emit            = 1'b1;
                        if (format_bad_next || k < CNT_W'(MIN_FRAME_SIZE - 1))
                            status_next = ST_MALFORMED;
                        else if (id_accum_next > {2'b00, max_servo_id_reg} ||
                                 pos_accum_next < min_position_reg ||
                                 pos_accum_next > max_position_reg)
                            status_next = ST_RANGE;
                        else
                        begin
                            status_next   = ST_VALID;
                            servo_id_next = id_accum_next[7:0];
                            position_next = pos_accum_next;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= '0;
            frame_done_reg   <= 1'b0;
            id_accum_reg     <= '0;
            pos_accum_reg    <= '0;
            format_bad_reg   <= 1'b0;
            digits_ended_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            frame_done_reg   <= frame_done_next;
            id_accum_reg     <= id_accum_next;
            pos_accum_reg    <= pos_accum_next;
            format_bad_reg   <= format_bad_next;
            digits_ended_reg <= digits_ended_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg   <= status_next;
            servo_id_reg <= servo_id_next;
            position_reg <= position_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {position_reg, servo_id_reg};
    assign m_axis_tuser  = status_reg;

    `SRFP_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, frame_count_reg <= CNT_LAST,
        "frame count beyond frame limit")
    `SRFP_ASSERT_NOW(a_done_has_frame, clk, rst_n, frame_done_reg,
        frame_count_reg >= CNT_W'(2), "closed frame with too few bytes")
    `SRFP_ASSERT_NOW(a_reject_zero, clk, rst_n, m_axis_tvalid && status_reg != ST_VALID,
        m_axis_tdata == 24'd0, "rejected frame carries nonzero data")
    `SRFP_ASSERT_NEXT(a_start_opens, clk, rst_n, in_accept && s_axis_tdata == CH_START,
        frame_count_reg == CNT_W'(1) && !frame_done_reg, "start byte did not open a frame")

endmodule
